@@ rtl/core/ems_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enclave measurement SHA-256 package
// Shared types, constants and the SHA-256 round helpers.
// ----------------------------------------------------------------------------
package ems_pkg;

  localparam int unsigned ExtendBlocks = 4;
  localparam int unsigned PendW = $clog2(ExtendBlocks * 8 + 1);

  typedef enum logic [2:0] {
    ACT_CREATE   = 3'd0,
    ACT_ADD      = 3'd1,
    ACT_EXTEND   = 3'd2,
    ACT_EXT_ZERO = 3'd3,
    ACT_DATA     = 3'd4,
    ACT_FINAL    = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] ssa_frame_size;
    logic [63:0] size_or_offset;
    logic [63:0] page_flags;
    logic [63:0] data_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
    logic        seq_error;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_cmd_t;

  localparam logic [63:0] MagicCreate = 64'h0045_5441_4552_4345;
  localparam logic [63:0] MagicAdd    = 64'h0000_0000_4444_4145;
  localparam logic [63:0] MagicExtend = 64'h0044_4E45_5458_4545;

  localparam logic [255:0] Iv = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
          32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
          32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
          32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
          32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
          32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
          32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
          32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
          32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
          32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

@@ rtl/core/ems_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Shared compression engine: one round per cycle over a 16-word schedule window.
// ----------------------------------------------------------------------------
module ems_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ems_pkg::core_cmd_t cmd_i,
  input  logic [511:0]      block_i,
  output logic              busy_o,
  output logic [255:0]      chain_o
);

  logic [255:0] chain_q, chain_d;
  logic [255:0] st_q, st_d;
  logic [511:0] w_q, w_d;
  logic [5:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d;

  logic [31:0] a, b, c, d, e, f, g, h, wt, t1, t2, w1, w14, w9, w0, s0, s1;

  always_comb begin
    {a, b, c, d, e, f, g, h} = st_q;
    wt  = w_q[511:480];
    w0  = w_q[511:480];
    w1  = w_q[479:448];
    w9  = w_q[223:192];
    w14 = w_q[63:32];
    s0  = ems_pkg::rotr(w1, 7) ^ ems_pkg::rotr(w1, 18) ^ (w1 >> 3);
    s1  = ems_pkg::rotr(w14, 17) ^ ems_pkg::rotr(w14, 19) ^ (w14 >> 10);
    t1  = h + (ems_pkg::rotr(e, 6) ^ ems_pkg::rotr(e, 11) ^ ems_pkg::rotr(e, 25))
          + ((e & f) ^ (~e & g)) + ems_pkg::round_k(rnd_q) + wt;
    t2  = (ems_pkg::rotr(a, 2) ^ ems_pkg::rotr(a, 13) ^ ems_pkg::rotr(a, 22))
          + ((a & b) ^ (a & c) ^ (b & c));
    chain_d = chain_q;
    st_d    = st_q;
    w_d     = w_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;
    if (cmd_i.init) begin
      chain_d = ems_pkg::Iv;
    end else if (cmd_i.start) begin
      st_d   = chain_q;
      w_d    = block_i;
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      st_d  = {t1 + t2, a, b, c, d + t1, e, f, g};
      w_d   = {w_q[479:0], w0 + s0 + w9 + s1};
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        busy_d = 1'b0;
        for (int i = 0; i < 8; i++) begin
          chain_d[i*32 +: 32] = chain_q[i*32 +: 32] + st_d[i*32 +: 32];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= ems_pkg::Iv;
      busy_q  <= 1'b0;
      rnd_q   <= '0;
    end else begin
      chain_q <= chain_d;
      busy_q  <= busy_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    w_q  <= w_d;
  end

  assign busy_o  = busy_q;
  assign chain_o = chain_q;

endmodule

@@ rtl/core/enclave_measurement_sha256_unit.sv @@
`timescale 1ns / 1ps
// Sequencing: records and full data blocks each take one compression; data
// words without a block end are absorbed without a compression; extend-zero takes 1+ExtendBlocks
// compressions; finalize takes one compression then puts out four result words.
// Throughput: one word at a time, set by the single shared round unit.
// Reset: chain value to the SHA-256 IV, byte count and pending words cleared.
// ----------------------------------------------------------------------------
// Enclave measurement SHA-256 unit
// Sequencer around the shared round unit that builds records and digests.
// ----------------------------------------------------------------------------
module enclave_measurement_sha256_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ems_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ems_pkg::out_word_t out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_OUT   = 5'b01000,
    ST_ERR   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [511:0] blk_q, blk_d;
  logic [63:0]  bytes_q, bytes_d;
  logic [ems_pkg::PendW-1:0] pend_q, pend_d;
  logic [4:0]   zeros_q, zeros_d;
  logic         fin_q, fin_d;
  logic [1:0]   idx_q, idx_d;
  ems_pkg::core_cmd_t cmd;
  logic         busy;
  logic [255:0] chain;
  logic         acc, bad;
  logic [2:0]   act;
  logic [3:0]   pos;
  logic [63:0]  dw, bits;
  logic [63:0]  sel;

  ems_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .block_i (blk_q),
    .busy_o  (busy),
    .chain_o (chain)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc = in_valid_i && !in_stall_o;
  assign act = in_data_i.action;
  assign bad = (act > 3'(ems_pkg::ACT_FINAL)) ||
               ((act == 3'(ems_pkg::ACT_DATA)) ? (pend_q == '0) : (pend_q != '0));

  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    bytes_d = bytes_q;
    pend_d  = pend_q;
    zeros_d = zeros_q;
    fin_d   = fin_q;
    idx_d   = idx_q;
    cmd     = '0;
    dw      = in_data_i.data_word;
    pos     = {3'((ems_pkg::PendW)'(ems_pkg::ExtendBlocks * 8) - pend_q), 1'b0};
    bits    = {bytes_q[60:0], 3'b000};
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (bad) begin
            state_d = ST_ERR;
          end else begin
            state_d = ST_START;
            fin_d   = 1'b0;
            zeros_d = '0;
            unique case (act)
              3'(ems_pkg::ACT_CREATE): begin
                cmd.init = 1'b1;
                bytes_d  = 64'd64;
                blk_d    = '0;
                blk_d[511:448] = {ems_pkg::bswap(ems_pkg::MagicCreate[31:0]),
                                  ems_pkg::bswap(ems_pkg::MagicCreate[63:32])};
                blk_d[447:352] = {ems_pkg::bswap(in_data_i.ssa_frame_size),
                                  ems_pkg::bswap(in_data_i.size_or_offset[31:0]),
                                  ems_pkg::bswap(in_data_i.size_or_offset[63:32])};
              end
              3'(ems_pkg::ACT_ADD): begin
                bytes_d = bytes_q + 64'd64;
                blk_d   = '0;
                blk_d[511:448] = {ems_pkg::bswap(ems_pkg::MagicAdd[31:0]),
                                  ems_pkg::bswap(ems_pkg::MagicAdd[63:32])};
                blk_d[447:320] = {ems_pkg::bswap(in_data_i.size_or_offset[31:0]),
                                  ems_pkg::bswap(in_data_i.size_or_offset[63:32]),
                                  ems_pkg::bswap(in_data_i.page_flags[31:0]),
                                  ems_pkg::bswap(in_data_i.page_flags[63:32])};
              end
              3'(ems_pkg::ACT_EXTEND), 3'(ems_pkg::ACT_EXT_ZERO): begin
                bytes_d = bytes_q + 64'd64;
                blk_d   = '0;
                blk_d[511:448] = {ems_pkg::bswap(ems_pkg::MagicExtend[31:0]),
                                  ems_pkg::bswap(ems_pkg::MagicExtend[63:32])};
                blk_d[447:384] = {ems_pkg::bswap(in_data_i.size_or_offset[31:0]),
                                  ems_pkg::bswap(in_data_i.size_or_offset[63:32])};
                if (act == 3'(ems_pkg::ACT_EXTEND)) begin
                  pend_d = (ems_pkg::PendW)'(ems_pkg::ExtendBlocks * 8);
                end else begin
                  zeros_d = 5'(ems_pkg::ExtendBlocks);
                end
              end
              3'(ems_pkg::ACT_DATA): begin
                blk_d[511 - 32*pos -: 32] = ems_pkg::bswap(dw[31:0]);
                blk_d[479 - 32*pos -: 32] = ems_pkg::bswap(dw[63:32]);
                pend_d = pend_q - 1'b1;
                if (pos == 4'd14) begin
                  bytes_d = bytes_q + 64'd64;
                end else begin
                  state_d = ST_IDLE;
                end
              end
              3'(ems_pkg::ACT_FINAL): begin
                fin_d = 1'b1;
                blk_d = {32'h80000000, 416'd0, bits};
              end
              default: state_d = ST_ERR;
            endcase
          end
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (!busy) begin
          if (zeros_q != '0) begin
            zeros_d = zeros_q - 5'd1;
            bytes_d = bytes_q + 64'd64;
            blk_d   = '0;
            state_d = ST_START;
          end else if (fin_q) begin
            idx_d   = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            cmd.init = 1'b1;
            bytes_d  = '0;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sel = {chain[255 - 64*idx_q -: 32], chain[223 - 64*idx_q -: 32]};
    out_valid_o = (state_q == ST_OUT) || (state_q == ST_ERR);
    out_data_o.digest_word = '0;
    out_data_o.word_index  = '0;
    out_data_o.last        = 1'b1;
    out_data_o.seq_error   = 1'b1;
    if (state_q == ST_OUT) begin
      out_data_o.digest_word = {ems_pkg::bswap(sel[31:0]), ems_pkg::bswap(sel[63:32])};
      out_data_o.word_index  = idx_q;
      out_data_o.last        = (idx_q == 2'd3);
      out_data_o.seq_error   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bytes_q <= '0;
      pend_q  <= '0;
      zeros_q <= '0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      bytes_q <= bytes_d;
      pend_q  <= pend_d;
      zeros_q <= zeros_d;
      fin_q   <= fin_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o) else $error("accepted while compressing");
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= (ems_pkg::PendW)'(ems_pkg::ExtendBlocks * 8)) else $error("pending overflow");
  a_out_idle_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy) else $error("result while compressing");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Enclave measurement SHA-256 unit testbench
// Drives create, add, extend, data and finalize words with random gaps and
// stalls, predicts digests and sequence errors with a SHA-256 measurement
// model, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WordsPerExtend = ems_pkg::ExtendBlocks * 8;
  localparam int unsigned WatchLimit = 20000;
  localparam logic [2:0] ActBad6 = 3'd6;
  localparam logic [2:0] ActBad7 = 3'd7;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  ems_pkg::in_word_t  in_data;
  logic              out_valid;
  logic              out_stall;
  ems_pkg::out_word_t out_data;

  enclave_measurement_sha256_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // measurement state
  logic [31:0] hash_state [8];
  logic [31:0] msg_block [16];
  logic [63:0] byte_count;
  int unsigned data_owed;

  ems_pkg::in_word_t  word_queue [$];
  ems_pkg::out_word_t digest_queue [$];
  int unsigned fail_count;
  bit          stim_done;
  bit          hold_rx;
  int unsigned hold_left;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] s [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) s[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + ems_pkg::round_k(i[5:0]) + w[i];
      t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
      s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += s[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = ems_pkg::Iv[255 - 32*i -: 32];
    byte_count = '0;
  endtask

  // record is 64 bytes, byte 0 at bits 7:0
  task automatic absorb_record(logic [511:0] rec);
    for (int i = 0; i < 16; i++)
      msg_block[i] = {rec[32*i +: 8], rec[32*i+8 +: 8], rec[32*i+16 +: 8], rec[32*i+24 +: 8]};
    sha_compress();
    byte_count += 64;
  endtask

  task automatic predict_measurement(ems_pkg::in_word_t w);
    logic [511:0] rec;
    int unsigned pos;
    logic [63:0] bits, dw;
    ems_pkg::out_word_t r;
    if (w.action > ems_pkg::ACT_FINAL ||
        ((w.action == ems_pkg::ACT_DATA) ? data_owed == 0 : data_owed != 0)) begin
      r = '{digest_word: '0, word_index: '0, last: 1'b1, seq_error: 1'b1};
      digest_queue.push_back(r);
      return;
    end
    rec = '0;
    case (w.action)
      ems_pkg::ACT_CREATE: begin
        restart_hash();
        rec[63:0] = ems_pkg::MagicCreate;
        rec[95:64] = w.ssa_frame_size;
        rec[159:96] = w.size_or_offset;
        absorb_record(rec);
      end
      ems_pkg::ACT_ADD: begin
        rec[63:0] = ems_pkg::MagicAdd;
        rec[127:64] = w.size_or_offset;
        rec[191:128] = w.page_flags;
        absorb_record(rec);
      end
      ems_pkg::ACT_EXTEND, ems_pkg::ACT_EXT_ZERO: begin
        rec[63:0] = ems_pkg::MagicExtend;
        rec[127:64] = w.size_or_offset;
        absorb_record(rec);
        if (w.action == ems_pkg::ACT_EXTEND) begin
          data_owed = WordsPerExtend;
        end else begin
          for (int i = 0; i < ems_pkg::ExtendBlocks; i++) absorb_record('0);
        end
      end
      ems_pkg::ACT_DATA: begin
        pos = ((WordsPerExtend - data_owed) % 8) * 2;
        dw = w.data_word;
        msg_block[pos] = {dw[7:0], dw[15:8], dw[23:16], dw[31:24]};
        msg_block[pos+1] = {dw[39:32], dw[47:40], dw[55:48], dw[63:56]};
        data_owed--;
        if (pos == 14) begin
          sha_compress();
          byte_count += 64;
        end
      end
      default: begin
        bits = byte_count << 3;
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        msg_block[0] = 32'h8000_0000;
        msg_block[14] = bits[63:32];
        msg_block[15] = bits[31:0];
        sha_compress();
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 8; j++)
            r.digest_word[8*j +: 8] = hash_state[2*i + j/4][24 - 8*(j%4) +: 8];
          r.word_index = i[1:0];
          r.last = (i == 3);
          r.seq_error = 1'b0;
          digest_queue.push_back(r);
        end
        restart_hash();
      end
    endcase
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic ems_pkg::in_word_t make_word(ems_pkg::action_e act);
    ems_pkg::in_word_t w;
    w.action = act;
    w.ssa_frame_size = $urandom();
    w.size_or_offset = rand64();
    w.page_flags = rand64();
    w.data_word = rand64();
    return w;
  endfunction

  task automatic queue_extend();
    word_queue.push_back(make_word(ems_pkg::ACT_EXTEND));
    for (int i = 0; i < WordsPerExtend; i++) word_queue.push_back(make_word(ems_pkg::ACT_DATA));
  endtask

  task automatic queue_noise();
    ems_pkg::in_word_t w;
    w = make_word(ems_pkg::ACT_CREATE);
    w.action = 3'($urandom_range(0, 7));
    word_queue.push_back(w);
  endtask

  // driver
  int unsigned tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      tx_gap <= 0;
      stim_done <= 1'b0;
      data_owed = 0;
      restart_hash();
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_measurement(in_data);
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (word_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= word_queue.pop_front();
        tx_gap <= ($urandom_range(0, 3) == 0)
                  ? (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                  : 0;
      end else begin
        in_valid <= 1'b0;
        if (!in_valid) stim_done <= 1'b1;
      end
    end
  end

  // monitor and receiver stall
  int unsigned rx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
      hold_rx <= 1'b1;
      hold_left <= 400;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          $error("unexpected result word %h", out_data);
          fail_count++;
        end else begin
          ems_pkg::out_word_t e;
          e = digest_queue.pop_front();
          if (out_data.digest_word !== e.digest_word) begin
            $error("digest_word expected %h actual %h", e.digest_word, out_data.digest_word);
            fail_count++;
          end
          if (out_data.word_index !== e.word_index) begin
            $error("word_index expected %0d actual %0d", e.word_index, out_data.word_index);
            fail_count++;
          end
          if (out_data.last !== e.last) begin
            $error("last expected %0b actual %0b", e.last, out_data.last);
            fail_count++;
          end
          if (out_data.seq_error !== e.seq_error) begin
            $error("seq_error expected %0b actual %0b", e.seq_error, out_data.seq_error);
            fail_count++;
          end
        end
      end
      if (hold_rx) begin
        out_stall <= 1'b1;
        if (hold_left != 0) hold_left <= hold_left - 1;
        else hold_rx <= 1'b0;
      end else if (rx_gap != 0) begin
        out_stall <= 1'b1;
        rx_gap <= rx_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  int unsigned idle_cycles;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    ems_pkg::in_word_t w;

    // directed: finalize after reset, bad codes, extremes, each action
    word_queue.push_back(make_word(ems_pkg::ACT_FINAL));
    w = make_word(ems_pkg::ACT_DATA); word_queue.push_back(w);
    w.action = ActBad6; word_queue.push_back(w);
    w.action = ActBad7; word_queue.push_back(w);
    w = '{action: ems_pkg::ACT_CREATE, ssa_frame_size: '1, size_or_offset: '1, page_flags: '1,
          data_word: '1};
    word_queue.push_back(w);
    w.action = ems_pkg::ACT_ADD; word_queue.push_back(w);
    w.action = ems_pkg::ACT_EXT_ZERO; word_queue.push_back(w);
    w = '0; w.action = ems_pkg::ACT_ADD; word_queue.push_back(w);
    w.action = ems_pkg::ACT_FINAL; word_queue.push_back(w);
    w = '0; word_queue.push_back(w);
    w.action = ems_pkg::ACT_EXTEND; word_queue.push_back(w);
    w = make_word(ems_pkg::ACT_FINAL); word_queue.push_back(w);
    for (int i = 0; i < WordsPerExtend; i++) begin
      w = make_word(ems_pkg::ACT_DATA);
      w.data_word = (i % 2) ? '1 : '0;
      word_queue.push_back(w);
    end
    word_queue.push_back(make_word(ems_pkg::ACT_FINAL));

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // random measurement sessions
    while (word_queue.size() < 260) begin
      word_queue.push_back(make_word(ems_pkg::ACT_CREATE));
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: word_queue.push_back(make_word(ems_pkg::ACT_ADD));
          3: word_queue.push_back(make_word(ems_pkg::ACT_EXT_ZERO));
          4, 5, 6: queue_extend();
          default: queue_noise();
        endcase
      end
      word_queue.push_back(make_word(ems_pkg::ACT_FINAL));
      if ($urandom_range(0, 3) == 0) queue_noise();
    end

    wait (stim_done && digest_queue.size() == 0);
    repeat (700) @(posedge clk_i);
    if (fail_count == 0 && digest_queue.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
